### rtl/hdrs_pkg.sv
// ----------------------------------------------------------------------------
// hdrs_pkg
// Types and constants shared by the report descriptor scanner files.
// ----------------------------------------------------------------------------
package hdrs_pkg;

   // parser phase within the current item
   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_LLEN   = 2'd1,
      PH_LTAG   = 2'd2,
      PH_DATA   = 2'd3
   } phase_type;

   // item prefix codes
   localparam logic [7:0] LONG_PREFIX   = 8'hFE;
   localparam logic [1:0] SIZE_FOUR     = 2'd3;
   localparam logic [7:0] TAG_MASK      = 8'hFC;
   localparam logic [7:0] REPORT_ID_TAG = 8'h84;

   // keyboard layout constants
   localparam logic [15:0] MAX_REPORT_LEN = 16'd64;
   localparam logic [6:0]  LEN_ID_DEFAULT = 7'd9;
   localparam logic [6:0]  LEN_NO_ID      = 7'd8;
   localparam logic [2:0]  KEY_SLOTS      = 3'd6;
   localparam logic        MOD_OFF_ID     = 1'b1;
   localparam logic        MOD_OFF_NO_ID  = 1'b0;
   localparam logic [1:0]  KEYS_OFF_ID    = 2'd3;
   localparam logic [1:0]  KEYS_OFF_NO_ID = 2'd2;

   // one result word
   typedef struct packed {
      logic [7:0] found_report_id;
      logic       modifier_offset;
      logic [1:0] keys_offset;
      logic [2:0] key_slots;
      logic [6:0] report_length;
      logic       layout_ok;
   } rsp_type;

endpackage

### rtl/hdrs_if.sv
// ----------------------------------------------------------------------------
// hdrs channel interfaces
// Valid/ready channels for descriptor bytes, layout results and the
// max packet register write.
// ----------------------------------------------------------------------------
interface hdrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       final_byte;

   modport source (output valid, output desc_byte, output final_byte, input ready);
   modport sink (input valid, input desc_byte, input final_byte, output ready);
endinterface

interface hdrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] found_report_id;
   logic       modifier_offset;
   logic [1:0] keys_offset;
   logic [2:0] key_slots;
   logic [6:0] report_length;
   logic       layout_ok;

   modport source (output valid, output found_report_id, output modifier_offset,
                   output keys_offset, output key_slots, output report_length,
                   output layout_ok, input ready);
   modport sink (input valid, input found_report_id, input modifier_offset,
                 input keys_offset, input key_slots, input report_length,
                 input layout_ok, output ready);
endinterface

interface hdrs_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] max_packet;

   modport source (output valid, output max_packet, input ready);
   modport sink (input valid, input max_packet, output ready);
endinterface

### rtl/hdrs_parser.sv
// ----------------------------------------------------------------------------
// hdrs_parser
// Item tokenizer and report ID capture, one descriptor byte per step, with
// the keyboard layout derived for the final byte.
// ----------------------------------------------------------------------------
module hdrs_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          desc_byte,
   input  logic                final_byte,
   input  logic [15:0]         max_packet,
   output hdrs_pkg::rsp_type   result
);

   hdrs_pkg::phase_type phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic       is_id_ff, is_id_in;
   logic [7:0] pend_ff, pend_in;
   logic [7:0] held_ff, held_in;

   logic [1:0] size_code;
   logic [2:0] size_bytes;
   logic [7:0] left_dec;
   logic [7:0] data_id;

   assign size_code  = desc_byte[1:0];
   assign size_bytes = (size_code == hdrs_pkg::SIZE_FOUR) ? 3'd4 : {1'b0, size_code};
   assign left_dec   = left_ff - 8'd1;
   assign data_id    = is_id_ff ? desc_byte : pend_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         hdrs_pkg::PH_PREFIX: begin
            if (desc_byte == hdrs_pkg::LONG_PREFIX) begin
               phase_in = hdrs_pkg::PH_LLEN;
            end else if (size_code != 2'd0) begin
               phase_in = hdrs_pkg::PH_DATA;
            end
         end
         hdrs_pkg::PH_LLEN: begin
            phase_in = hdrs_pkg::PH_LTAG;
         end
         hdrs_pkg::PH_LTAG: begin
            phase_in = (left_ff == 8'd0) ? hdrs_pkg::PH_PREFIX : hdrs_pkg::PH_DATA;
         end
         hdrs_pkg::PH_DATA: begin
            if (left_dec == 8'd0) begin
               phase_in = hdrs_pkg::PH_PREFIX;
            end
         end
         default: phase_in = hdrs_pkg::PH_PREFIX;
      endcase
   end

   // byte count, id tracking and capture
   always_comb begin
      left_in  = left_ff;
      is_id_in = is_id_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      unique case (phase_ff)
         hdrs_pkg::PH_PREFIX: begin
            pend_in  = 8'd0;
            is_id_in = 1'b0;
            if (desc_byte != hdrs_pkg::LONG_PREFIX && size_code != 2'd0) begin
               is_id_in = ((desc_byte & hdrs_pkg::TAG_MASK) == hdrs_pkg::REPORT_ID_TAG);
               left_in  = {5'd0, size_bytes};
            end
         end
         hdrs_pkg::PH_LLEN: begin
            left_in = desc_byte;
         end
         hdrs_pkg::PH_LTAG: begin
            left_in = left_ff;
         end
         hdrs_pkg::PH_DATA: begin
            is_id_in = 1'b0;
            left_in  = left_dec;
            pend_in  = data_id;
            if (left_dec == 8'd0) begin
               pend_in = 8'd0;
               if (held_ff == 8'd0 && data_id != 8'd0) begin
                  held_in = data_id;
               end
            end
         end
         default: begin
            left_in = left_ff;
         end
      endcase
   end

   // layout from the id as it stands after this byte
   logic       id_found;
   logic       mp_in_range;
   logic [6:0] len;
   logic [1:0] keys_pos;

   assign id_found    = (held_in != 8'd0);
   assign mp_in_range = (max_packet != 16'd0) && (max_packet <= hdrs_pkg::MAX_REPORT_LEN);
   assign keys_pos    = id_found ? hdrs_pkg::KEYS_OFF_ID : hdrs_pkg::KEYS_OFF_NO_ID;

   always_comb begin
      if (id_found) begin
         len = mp_in_range ? max_packet[6:0] : hdrs_pkg::LEN_ID_DEFAULT;
      end else begin
         len = hdrs_pkg::LEN_NO_ID;
      end
   end

   always_comb begin
      result.found_report_id = held_in;
      result.modifier_offset = id_found ? hdrs_pkg::MOD_OFF_ID : hdrs_pkg::MOD_OFF_NO_ID;
      result.keys_offset     = keys_pos;
      result.key_slots       = hdrs_pkg::KEY_SLOTS;
      result.report_length   = len;
      result.layout_ok       = (len >= ({5'd0, keys_pos} + {4'd0, hdrs_pkg::KEY_SLOTS}));
   end

   // state registers; the final byte returns everything to its start value
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hdrs_pkg::PH_PREFIX;
         left_ff  <= 8'd0;
         is_id_ff <= 1'b0;
         pend_ff  <= 8'd0;
         held_ff  <= 8'd0;
      end else if (step) begin
         if (final_byte) begin
            phase_ff <= hdrs_pkg::PH_PREFIX;
            left_ff  <= 8'd0;
            is_id_ff <= 1'b0;
            pend_ff  <= 8'd0;
            held_ff  <= 8'd0;
         end else begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            is_id_ff <= is_id_in;
            pend_ff  <= pend_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

### rtl/hid_descriptor_report_id_scanner_core.sv
// ----------------------------------------------------------------------------
// hid_descriptor_report_id_scanner_core
// Scans a HID report descriptor for the first nonzero report ID and emits
// the keyboard report layout on the last byte.
// ----------------------------------------------------------------------------
// One descriptor byte is taken per cycle while no final byte is stalled in the
// input register. Each byte passes the input register, then the item parser
// updates its state and, on the byte marked final, the layout word is loaded
// into the output register, which presents the result word. Bytes that are not
// final produce no word. The input register keeps taking bytes while a result
// waits on the output; only a second final byte stalls until that result is
// taken.
// max_packet is written through the csr channel, which is always ready.
module hid_descriptor_report_id_scanner_core (
   input  logic        clock,
   input  logic        reset,
   hdrs_req_if.sink    req_ch,
   hdrs_rsp_if.source  rsp_ch,
   hdrs_csr_if.sink    csr_ch
);

   // max packet register
   logic [15:0] max_packet_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff <= 16'd0;
      end else if (csr_ch.valid) begin
         max_packet_ff <= csr_ch.max_packet;
      end
   end

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       step;
   logic       rsp_valid_ff;
   hdrs_pkg::rsp_type rsp_data_ff;
   hdrs_pkg::rsp_type result;

   assign step         = in_valid_ff && (!in_final_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.desc_byte;
         in_final_ff <= req_ch.final_byte;
      end
   end

   // item parser
   hdrs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .desc_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .max_packet (max_packet_ff),
      .result     (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_final_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_final_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.found_report_id = rsp_data_ff.found_report_id;
   assign rsp_ch.modifier_offset = rsp_data_ff.modifier_offset;
   assign rsp_ch.keys_offset     = rsp_data_ff.keys_offset;
   assign rsp_ch.key_slots       = rsp_data_ff.key_slots;
   assign rsp_ch.report_length   = rsp_data_ff.report_length;
   assign rsp_ch.layout_ok       = rsp_data_ff.layout_ok;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for hid_descriptor_report_id_scanner_core
// Streams HID report descriptors into the scanner with bursty input and a
// stalling result side, models the item parser and report ID capture, and
// checks every layout word against the model or the directed table across
// several max_packet settings; one long result stall backs up the input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset;

   hdrs_req_if req_if ();
   hdrs_rsp_if rsp_if ();
   hdrs_csr_if csr_if ();

   hid_descriptor_report_id_scanner_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // one row of the directed descriptor table
   typedef struct {
      logic [7:0]        desc_byte;
      logic              final_byte;
      bit                fixed;
      hdrs_pkg::rsp_type layout;
   } desc_row_type;

   localparam hdrs_pkg::rsp_type NO_ID_LAYOUT =
      '{8'h00, hdrs_pkg::MOD_OFF_NO_ID, hdrs_pkg::KEYS_OFF_NO_ID, hdrs_pkg::KEY_SLOTS,
        hdrs_pkg::LEN_NO_ID, 1'b1};

   // directed descriptors, all run with max_packet at its reset value
   desc_row_type directed_rows [0:23] = '{
      // lone main item with no data
      '{8'h00, 1'b1, 1'b1, NO_ID_LAYOUT},
      // id 5 captured, then a four byte item cut off by the end
      '{8'h85, 1'b0, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1,
        '{8'h05, hdrs_pkg::MOD_OFF_ID, hdrs_pkg::KEYS_OFF_ID, hdrs_pkg::KEY_SLOTS,
          hdrs_pkg::LEN_ID_DEFAULT, 1'b1}},
      // zero id skipped, two byte id item completing on the last byte
      '{8'h85, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h86, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1,
        '{8'hFF, hdrs_pkg::MOD_OFF_ID, hdrs_pkg::KEYS_OFF_ID, hdrs_pkg::KEY_SLOTS,
          hdrs_pkg::LEN_ID_DEFAULT, 1'b1}},
      // long item hiding an id, empty id item, zero length long item, cut id
      '{8'hFE, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h85, 1'b0, 1'b0, '0},
      '{8'h07, 1'b0, 1'b0, '0},
      '{8'h84, 1'b0, 1'b0, '0},
      '{8'hFE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, '0},
      '{8'h85, 1'b1, 1'b1, NO_ID_LAYOUT},
      // four byte id item, low byte taken
      '{8'h87, 1'b0, 1'b0, '0},
      '{8'h2A, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b1,
        '{8'h2A, hdrs_pkg::MOD_OFF_ID, hdrs_pkg::KEYS_OFF_ID, hdrs_pkg::KEY_SLOTS,
          hdrs_pkg::LEN_ID_DEFAULT, 1'b1}}
   };

   // parser model state
   hdrs_pkg::phase_type scan_phase;
   logic [8:0]  scan_left;
   bit          scan_in_id;
   logic [7:0]  scan_pending;
   logic [7:0]  scan_held;
   logic [15:0] cur_max_packet;

   hdrs_pkg::rsp_type expected_layouts [$];
   logic [7:0]  desc_bytes [$];
   int unsigned mismatches = 0;
   int unsigned burst_left = 0;
   bit          no_gaps = 1'b0;
   bit          hold_request = 1'b0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // return the parser to the start of a descriptor
   function automatic void clear_scan();
      scan_phase   = hdrs_pkg::PH_PREFIX;
      scan_left    = '0;
      scan_in_id   = 1'b0;
      scan_pending = '0;
      scan_held    = '0;
   endfunction

   // advance the item parser by one descriptor byte
   function automatic void scan_byte(logic [7:0] b);
      logic [8:0] size;
      case (scan_phase)
         hdrs_pkg::PH_PREFIX: begin
            scan_pending = '0;
            scan_in_id   = 1'b0;
            if (b == hdrs_pkg::LONG_PREFIX) begin
               scan_phase = hdrs_pkg::PH_LLEN;
            end else begin
               size = (b[1:0] == hdrs_pkg::SIZE_FOUR) ? 9'd4 : {7'd0, b[1:0]};
               if (size != 0) begin
                  scan_in_id = ((b & hdrs_pkg::TAG_MASK) == hdrs_pkg::REPORT_ID_TAG);
                  scan_left  = size;
                  scan_phase = hdrs_pkg::PH_DATA;
               end
            end
         end
         hdrs_pkg::PH_LLEN: begin
            scan_left  = {1'b0, b};
            scan_phase = hdrs_pkg::PH_LTAG;
         end
         hdrs_pkg::PH_LTAG: begin
            scan_phase = (scan_left == 0) ? hdrs_pkg::PH_PREFIX : hdrs_pkg::PH_DATA;
         end
         default: begin
            // low data byte of an id item is its first one
            if (scan_in_id) begin
               scan_pending = b;
               scan_in_id   = 1'b0;
            end
            scan_left = scan_left - 9'd1;
            if (scan_left == 0) begin
               if (scan_held == 0 && scan_pending != 0) scan_held = scan_pending;
               scan_pending = '0;
               scan_phase   = hdrs_pkg::PH_PREFIX;
            end
         end
      endcase
   endfunction

   // keyboard layout for the id held so far
   function automatic hdrs_pkg::rsp_type current_layout();
      hdrs_pkg::rsp_type lay;
      int unsigned       len;
      lay.found_report_id = scan_held;
      lay.key_slots       = hdrs_pkg::KEY_SLOTS;
      if (scan_held != 0) begin
         lay.modifier_offset = hdrs_pkg::MOD_OFF_ID;
         lay.keys_offset     = hdrs_pkg::KEYS_OFF_ID;
         len = (cur_max_packet >= 1 && cur_max_packet <= hdrs_pkg::MAX_REPORT_LEN) ?
               cur_max_packet : hdrs_pkg::LEN_ID_DEFAULT;
      end else begin
         lay.modifier_offset = hdrs_pkg::MOD_OFF_NO_ID;
         lay.keys_offset     = hdrs_pkg::KEYS_OFF_NO_ID;
         len = hdrs_pkg::LEN_NO_ID;
      end
      lay.report_length = len[6:0];
      lay.layout_ok     = (len >= lay.keys_offset + hdrs_pkg::KEY_SLOTS);
      return lay;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // offer one word, model it once taken, then maybe open a gap
   task automatic send_word(input logic [7:0] b, input logic fin, input bit fixed,
                            input hdrs_pkg::rsp_type fixed_layout);
      int unsigned gap;
      req_if.valid      <= 1'b1;
      req_if.desc_byte  <= b;
      req_if.final_byte <= fin;
      do @(posedge clock); while (!req_if.ready);
      scan_byte(b);
      if (fin) begin
         expected_layouts.push_back(fixed ? fixed_layout : current_layout());
         clear_scan();
      end
      if (burst_left != 0) burst_left--;
      if (burst_left == 0 && !no_gaps) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drop valid and let every pending layout drain
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_layouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_packet(input logic [15:0] value);
      csr_if.valid      <= 1'b1;
      csr_if.max_packet <= value;
      do @(posedge clock); while (!csr_if.ready);
      cur_max_packet = value;
      csr_if.valid <= 1'b0;
   endtask

   // one random descriptor, mostly well formed items, some noise and cuts
   task automatic build_descriptor();
      int unsigned items, kind, n, len, i, cut;
      logic [7:0]  p;
      desc_bytes.delete();
      items = $urandom_range(1, 5);
      repeat (items) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            // report id item, sometimes empty or zero
            p = hdrs_pkg::REPORT_ID_TAG |
                8'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
            n = (p[1:0] == hdrs_pkg::SIZE_FOUR) ? 4 : p[1:0];
            desc_bytes.push_back(p);
            for (i = 0; i < n; i++) begin
               if (i == 0 && $urandom_range(0, 4) == 0) desc_bytes.push_back(8'h00);
               else desc_bytes.push_back(8'($urandom));
            end
         end else if (kind < 70) begin
            // any short item
            do p = 8'($urandom); while (p == hdrs_pkg::LONG_PREFIX);
            n = (p[1:0] == hdrs_pkg::SIZE_FOUR) ? 4 : p[1:0];
            desc_bytes.push_back(p);
            repeat (n) desc_bytes.push_back(8'($urandom));
         end else if (kind < 85) begin
            // long item, mostly short data
            n = $urandom_range(0, 49);
            len = (n == 0) ? 255 : (n < 5) ? $urandom_range(4, 40) : $urandom_range(0, 3);
            desc_bytes.push_back(hdrs_pkg::LONG_PREFIX);
            desc_bytes.push_back(8'(len));
            desc_bytes.push_back(8'($urandom));
            repeat (len) desc_bytes.push_back(8'($urandom));
         end else begin
            desc_bytes.push_back(8'($urandom));
         end
      end
      // end the descriptor inside an item now and then
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, desc_bytes.size());
         while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
      end
   endtask

   task automatic run_random(input int unsigned word_goal);
      int unsigned sent, i;
      sent = 0;
      while (sent < word_goal) begin
         build_descriptor();
         for (i = 0; i < desc_bytes.size(); i++) begin
            send_word(desc_bytes[i], i == desc_bytes.size() - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // result side: changing stall pattern, one long hold-off when asked
   initial begin : rsp_stall
      int unsigned cycle_cnt, hold_left, mode;
      bit          hold_taken;
      cycle_cnt  = 0;
      hold_left  = 0;
      mode       = 0;
      hold_taken = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = 300;
            hold_taken = 1'b1;
         end
         if (cycle_cnt % 50 == 0) mode = $urandom_range(0, 2);
         cycle_cnt++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // compare each layout word with the oldest expectation
   always @(posedge clock) begin : layout_check
      hdrs_pkg::rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_layouts.size() == 0) begin
            $display("%0t: unexpected layout word, expected none, got id %0d len %0d",
                     $time, rsp_if.found_report_id, rsp_if.report_length);
            mismatches++;
         end else begin
            want = expected_layouts.pop_front();
            check_field("found_report_id", want.found_report_id, rsp_if.found_report_id);
            check_field("modifier_offset", want.modifier_offset, rsp_if.modifier_offset);
            check_field("keys_offset", want.keys_offset, rsp_if.keys_offset);
            check_field("key_slots", want.key_slots, rsp_if.key_slots);
            check_field("report_length", want.report_length, rsp_if.report_length);
            check_field("layout_ok", want.layout_ok, rsp_if.layout_ok);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      logic [15:0] packet_sizes [0:7];
      int unsigned i;
      packet_sizes = '{16'd1, 16'd64, 16'd65, 16'hFFFF, 16'd8, 16'd9, 16'd0, 16'd0};
      packet_sizes[6] = 16'($urandom_range(1, 64));
      packet_sizes[7] = 16'($urandom);
      reset = 1'b1;
      req_if.valid      = 1'b0;
      req_if.desc_byte  = '0;
      req_if.final_byte = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.max_packet = '0;
      cur_max_packet    = '0;
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (i = 0; i < 24; i++)
         send_word(directed_rows[i].desc_byte, directed_rows[i].final_byte,
                   directed_rows[i].fixed, directed_rows[i].layout);
      settle();

      // random descriptors under each packet size
      foreach (packet_sizes[k]) begin
         write_max_packet(packet_sizes[k]);
         run_random(45);
         settle();
      end

      // back-to-back last bytes against a long result stall
      write_max_packet(16'd32);
      no_gaps      = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_word(8'($urandom), 1'b1, 1'b0, '0);
      settle();
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
